/* hdl/dkrm_pkg.sv */
// Shared types and constants for the duplicate-key run mean block.
`timescale 1ns / 1ps
package dkrm_pkg;

    // Fixed widths of the result fields
    localparam int KEY_BITS       = 32;
    localparam int MEAN_BITS      = 32;
    localparam int OUT_COUNT_BITS = 16;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Back-end divider sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_DIVIDE,
        B_DONE
    } back_state_t;

endpackage

/* hdl/dkrm_queue.sv */
// Small job queue that decouples the run tracker from the divider.
`timescale 1ns / 1ps
module dkrm_queue #(
    parameter int WIDTH = 100
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import dkrm_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg;
    logic [CNT_BITS-1:0] fill_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (fill_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/dkrm_front.sv */
// Front end: accepts points, tracks the open run and queues run-close jobs.
`timescale 1ns / 1ps
module dkrm_front #(
    parameter int COUNT_BITS = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dkrm_pkg::KEY_BITS-1:0] x_position,
    input  logic [31:0]                   y_sample,
    input  logic                          end_of_data,
    output logic                          job_push,
    output logic [dkrm_pkg::KEY_BITS+COUNT_BITS
                  + ((SAMPLE_BITS < 32) ? SAMPLE_BITS : 32) + COUNT_BITS + 1:0] job_data,
    input  logic                          job_full
);
    import dkrm_pkg::*;

    localparam int EFF_BITS = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam int SUM_BITS = EFF_BITS + COUNT_BITS;

    logic                  open_reg;
    logic                  open_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  pend_reg;
    logic                  pend_next;

    logic                  accept;
    logic                  close_old;
    logic [SUM_BITS-1:0]   y_ext;
    logic [KEY_BITS-1:0]   upd_key;
    logic [SUM_BITS-1:0]   upd_sum;
    logic [COUNT_BITS-1:0] upd_count;
    logic                  upd_ovf;

    assign in_stall = pend_reg || job_full;
    assign accept   = in_valid && !in_stall;
    assign y_ext    = {{COUNT_BITS{y_sample[EFF_BITS-1]}}, y_sample[EFF_BITS-1:0]};
    assign close_old = open_reg && (x_position != key_reg);

    // Run state after folding in the arriving point
    always_comb
    begin
        if (!open_reg || close_old)
        begin
            upd_key   = x_position;
            upd_sum   = y_ext;
            upd_count = COUNT_BITS'(1);
            upd_ovf   = 1'b0;
        end
        else if (&count_reg)
        begin
            upd_key   = key_reg;
            upd_sum   = sum_reg;
            upd_count = count_reg;
            upd_ovf   = 1'b1;
        end
        else
        begin
            upd_key   = key_reg;
            upd_sum   = sum_reg + y_ext;
            upd_count = count_reg + 1'b1;
            upd_ovf   = ovf_reg;
        end
    end

    // Decide run update and job push
    always_comb
    begin
        open_next  = open_reg;
        key_next   = key_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        job_push   = 1'b0;
        job_data   = {1'b0, ovf_reg, count_reg, sum_reg, key_reg};
        if (pend_reg)
        begin
            // Flush the one-point run left by a key change with end of data
            job_data = {1'b1, ovf_reg, count_reg, sum_reg, key_reg};
            if (!job_full)
            begin
                job_push   = 1'b1;
                pend_next  = 1'b0;
                open_next  = 1'b0;
                key_next   = '0;
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
        else if (accept)
        begin
            if (close_old)
            begin
                job_push   = 1'b1;
                open_next  = 1'b1;
                key_next   = upd_key;
                sum_next   = upd_sum;
                count_next = upd_count;
                ovf_next   = upd_ovf;
                pend_next  = end_of_data;
            end
            else if (end_of_data)
            begin
                job_push   = 1'b1;
                job_data   = {1'b1, upd_ovf, upd_count, upd_sum, upd_key};
                open_next  = 1'b0;
                key_next   = '0;
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                open_next  = 1'b1;
                key_next   = upd_key;
                sum_next   = upd_sum;
                count_next = upd_count;
                ovf_next   = upd_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            key_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            key_reg   <= key_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

/* hdl/dkrm_back.sv */
// Back end: radix-4 iterative divider that turns run-close jobs into results.
`timescale 1ns / 1ps
module dkrm_back #(
    parameter int COUNT_BITS = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_empty,
    input  logic [dkrm_pkg::KEY_BITS+COUNT_BITS
                  + ((SAMPLE_BITS < 32) ? SAMPLE_BITS : 32) + COUNT_BITS + 1:0] job_data,
    output logic                                 job_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dkrm_pkg::KEY_BITS-1:0]        group_x,
    output logic [dkrm_pkg::MEAN_BITS-1:0]       group_mean,
    output logic [dkrm_pkg::OUT_COUNT_BITS-1:0]  group_count,
    output logic                                 count_saturated,
    output logic                                 last_group
);
    import dkrm_pkg::*;

    localparam int EFF_BITS  = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam int SUM_BITS  = EFF_BITS + COUNT_BITS;
    localparam int DIV_BITS  = SUM_BITS + (SUM_BITS % 2);
    localparam int ITERS     = DIV_BITS / 2;
    localparam int ITER_BITS = $clog2(ITERS + 1);
    localparam int SUM_LSB   = KEY_BITS;
    localparam int CNT_LSB   = KEY_BITS + SUM_BITS;
    localparam int OVF_POS   = CNT_LSB + COUNT_BITS;
    localparam int LAST_POS  = OVF_POS + 1;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [ITER_BITS-1:0]  iter_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [DIV_BITS-1:0]   dq_reg;
    logic                  neg_reg;
    logic                  ovf_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [KEY_BITS-1:0]   group_x_reg;
    logic [MEAN_BITS-1:0]  group_mean_reg;
    logic [OUT_COUNT_BITS-1:0] group_count_reg;
    logic                  count_saturated_reg;
    logic                  last_group_reg;

    logic                  step;
    logic                  load_out;
    logic                  out_free;
    logic [SUM_BITS-1:0]   job_sum;
    logic [SUM_BITS-1:0]   job_mag;
    logic [COUNT_BITS:0]   trial_a;
    logic [COUNT_BITS:0]   trial_b;
    logic                  bit_a;
    logic                  bit_b;
    logic [COUNT_BITS-1:0] rem_a;
    logic [COUNT_BITS-1:0] rem_b;
    logic [EFF_BITS-1:0]   quo_mag;
    logic [EFF_BITS-1:0]   quo_signed;
    logic [OUT_COUNT_BITS-1:0] count_out;

    assign job_sum  = job_data[SUM_LSB +: SUM_BITS];
    assign job_mag  = job_sum[SUM_BITS-1] ? (~job_sum + 1'b1) : job_sum;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = B_DIVIDE;
                end
            end
            B_DIVIDE:
            begin
                if (iter_reg == ITER_BITS'(1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        job_pop  = 1'b0;
        step     = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:   job_pop  = !job_empty;
            B_DIVIDE: step     = 1'b1;
            B_DONE:   load_out = out_free;
            default:  job_pop  = 1'b0;
        endcase
    end

    // Two restoring division steps per cycle
    always_comb
    begin
        trial_a = {rem_reg, dq_reg[DIV_BITS-1]};
        bit_a   = (trial_a >= {1'b0, div_reg});
        rem_a   = bit_a ? COUNT_BITS'(trial_a - {1'b0, div_reg}) : COUNT_BITS'(trial_a);
        trial_b = {rem_a, dq_reg[DIV_BITS-2]};
        bit_b   = (trial_b >= {1'b0, div_reg});
        rem_b   = bit_b ? COUNT_BITS'(trial_b - {1'b0, div_reg}) : COUNT_BITS'(trial_b);
    end

    // Apply the sign of the sum to the quotient magnitude
    assign quo_mag    = dq_reg[EFF_BITS-1:0];
    assign quo_signed = neg_reg ? (~quo_mag + 1'b1) : quo_mag;

    // Truncate or zero-extend the run count to the result field
    generate
        if (COUNT_BITS >= OUT_COUNT_BITS)
        begin : g_count_trunc
            assign count_out = div_reg[OUT_COUNT_BITS-1:0];
        end
        else
        begin : g_count_ext
            assign count_out = {{(OUT_COUNT_BITS-COUNT_BITS){1'b0}}, div_reg};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load a job, then shift the dividend through the divider
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            key_reg  <= job_data[KEY_BITS-1:0];
            div_reg  <= job_data[CNT_LSB +: COUNT_BITS];
            ovf_reg  <= job_data[OVF_POS];
            last_reg <= job_data[LAST_POS];
            neg_reg  <= job_sum[SUM_BITS-1];
            rem_reg  <= '0;
            dq_reg   <= DIV_BITS'(job_mag);
            iter_reg <= ITER_BITS'(ITERS);
        end
        else if (step)
        begin
            rem_reg  <= rem_b;
            dq_reg   <= {dq_reg[DIV_BITS-3:0], bit_a, bit_b};
            iter_reg <= iter_reg - 1'b1;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            group_x_reg         <= key_reg;
            group_mean_reg      <= {{(MEAN_BITS-EFF_BITS){quo_signed[EFF_BITS-1]}}, quo_signed};
            group_count_reg     <= count_out;
            count_saturated_reg <= ovf_reg;
            last_group_reg      <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign group_x         = group_x_reg;
    assign group_mean      = group_mean_reg;
    assign group_count     = group_count_reg;
    assign count_saturated = count_saturated_reg;
    assign last_group      = last_group_reg;

endmodule

/* hdl/duplicate_key_run_mean_top.sv */
// Top level of the duplicate-key run mean block.
`timescale 1ns / 1ps
// Averages y over runs of consecutive points that share the same x key. A point that
// extends or opens a run is accepted while the input is not stalled. Each closed run
// becomes a job in a four-entry queue; the back end takes one job at a time, divides the
// run sum by the count with a divider that retires two quotient bits a cycle, and then
// registers the result and presents it. Points keep flowing while the queue has room; a
// point that both changes the key and ends the data set yields two results, and the
// input stalls while the second job is queued. Counts saturate at 2^COUNT_BITS-1, after
// which further points of the run are dropped and count_saturated is set on the result.
module duplicate_key_run_mean_top #(
    parameter int COUNT_BITS = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dkrm_pkg::KEY_BITS-1:0]       x_position,
    input  logic [31:0]                         y_sample,
    input  logic                                end_of_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dkrm_pkg::KEY_BITS-1:0]       group_x,
    output logic [dkrm_pkg::MEAN_BITS-1:0]      group_mean,
    output logic [dkrm_pkg::OUT_COUNT_BITS-1:0] group_count,
    output logic                                count_saturated,
    output logic                                last_group
);
    import dkrm_pkg::*;

    localparam int EFF_BITS = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam int JOB_BITS = KEY_BITS + EFF_BITS + 2 * COUNT_BITS + 2;

    logic                job_push;
    logic                job_pop;
    logic                job_full;
    logic                job_empty;
    logic [JOB_BITS-1:0] push_data;
    logic [JOB_BITS-1:0] pop_data;

    dkrm_front #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_position  (x_position),
        .y_sample    (y_sample),
        .end_of_data (end_of_data),
        .job_push    (job_push),
        .job_data    (push_data),
        .job_full    (job_full)
    );

    dkrm_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_data),
        .pop       (job_pop),
        .pop_data  (pop_data),
        .full      (job_full),
        .empty     (job_empty)
    );

    dkrm_back #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_empty       (job_empty),
        .job_data        (pop_data),
        .job_pop         (job_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .group_x         (group_x),
        .group_mean      (group_mean),
        .group_count     (group_count),
        .count_saturated (count_saturated),
        .last_group      (last_group)
    );

endmodule
